FILE: hw/rtl/nsp_pkg.sv
// Shared types, character constants and helpers for the NMEA sentence parser.
`default_nettype none

package nsp_pkg;

    localparam int MAX_LEN_DEFAULT = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_FIX_OK = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GGA = 24'h474741;

    localparam int TIME_LEN = 9;
    localparam int LAT_LEN  = 10;
    localparam int LON_LEN  = 10;
    localparam int DATE_LEN = 6;

    localparam logic [3:0] FLD_TIME = 4'd1;
    localparam logic [3:0] FLD_STAT = 4'd2;
    localparam logic [3:0] FLD_LAT  = 4'd3;
    localparam logic [3:0] FLD_NS   = 4'd4;
    localparam logic [3:0] FLD_LON  = 4'd5;
    localparam logic [3:0] FLD_EW   = 4'd6;
    localparam logic [3:0] FLD_DATE = 4'd9;
    localparam logic [3:0] FLD_MAX  = 4'd15;

    typedef enum logic [1:0] {
        CODE_OK       = 2'd0,
        CODE_OVERFLOW = 2'd1,
        CODE_CHECKSUM = 2'd2,
        CODE_MISSED   = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_GGA   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       wr;
        logic [3:0] field;
        logic [3:0] offset;
        logic [7:0] data;
        logic       commit;
    } cap_ctrl_t;

    typedef struct packed {
        logic [7:0]  fix_char;
        logic [7:0]  north_south;
        logic [7:0]  east_west;
        logic [47:0] fix_date;
        logic [63:0] time_head;
        logic [7:0]  time_tail;
        logic [63:0] lat_head;
        logic [15:0] lat_tail;
        logic [63:0] lon_head;
        logic [15:0] lon_tail;
    } fix_fields_t;

    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) begin
            v = 4'(h - CH_ZERO);
        end else if (h >= 8'h41 && h <= 8'h46) begin
            v = 4'(h - 8'h37);
        end else if (h >= 8'h61 && h <= 8'h66) begin
            v = 4'(h - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nsp_frame.sv
// Frame tracker: count, checksum, type and field position, plus per-character decision.
`default_nettype none

module nsp_frame
    import nsp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] rx_char,
    output cap_ctrl_t       cap_ctrl,
    output code_t           code,
    output kind_t           kind
);

    localparam logic [8:0] LIMIT = 9'(MAX_LEN - 1);

    logic [7:0] count_reg,   count_next;
    logic [7:0] xor_reg,     xor_next;
    logic [7:0] recent_reg [3];
    logic [7:0] recent_next [3];
    logic [7:0] type_reg [3];
    logic [7:0] type_next [3];
    logic [3:0] field_reg,   field_next;
    logic [3:0] offset_reg,  offset_next;

    logic [8:0]  next_pos;
    logic        is_term;
    logic        restart;
    logic [7:0]  pos_eff;
    logic [7:0]  src_xor;
    logic [7:0]  src_r1;
    logic [7:0]  src_r2;
    logic [3:0]  src_field;
    logic [3:0]  src_offset;
    logic [7:0]  calc_sum;
    logic [7:0]  ref_sum;
    logic [23:0] type_word;

    assign next_pos  = {1'b0, count_reg} + 9'd1;
    assign is_term   = (rx_char == CH_CR) || (rx_char == CH_LF);
    assign calc_sum  = xor_reg ^ recent_reg[0] ^ recent_reg[1] ^ recent_reg[2];
    assign ref_sum   = {hex_value(recent_reg[1]), hex_value(recent_reg[2])};
    assign type_word = {type_reg[0], type_reg[1], type_reg[2]};

    always_comb begin
        code        = CODE_OK;
        kind        = KIND_NONE;
        restart     = 1'b0;
        count_next  = count_reg;
        xor_next    = 8'd0;
        recent_next = '{default: 8'd0};
        type_next   = '{default: 8'd0};
        field_next  = 4'd0;
        offset_next = 4'd0;

        cap_ctrl        = '0;
        cap_ctrl.step   = step;
        cap_ctrl.data   = rx_char;

        pos_eff    = count_reg;
        src_xor    = xor_reg;
        src_r1     = recent_reg[1];
        src_r2     = recent_reg[2];
        src_field  = field_reg;
        src_offset = offset_reg;

        if (next_pos > LIMIT) begin
            code           = CODE_OVERFLOW;
            count_next     = 8'd0;
            cap_ctrl.clear = 1'b1;
        end else if (is_term) begin
            count_next     = 8'd0;
            cap_ctrl.clear = 1'b1;
            if (count_reg != 8'd0) begin
                if (count_reg < 8'd4 || calc_sum != ref_sum) begin
                    code = CODE_CHECKSUM;
                end else if (type_word == TAG_RMC) begin
                    kind            = KIND_RMC;
                    cap_ctrl.commit = 1'b1;
                end else if (type_word == TAG_GGA) begin
                    kind = KIND_GGA;
                end else begin
                    kind = KIND_OTHER;
                end
            end
        end else begin
            // restart on a stray dollar: take it as position 0 of a cleared frame
            if (rx_char == CH_DOLLAR && count_reg != 8'd0) begin
                restart        = 1'b1;
                code           = CODE_MISSED;
                cap_ctrl.clear = 1'b1;
                pos_eff        = 8'd0;
                src_xor        = 8'd0;
                src_r1         = 8'd0;
                src_r2         = 8'd0;
                src_field      = 4'd0;
                src_offset     = 4'd0;
                count_next     = 8'd1;
            end else begin
                count_next = next_pos[7:0];
                type_next  = type_reg;
            end
            xor_next       = (pos_eff != 8'd0) ? (src_xor ^ rx_char) : src_xor;
            recent_next[0] = src_r1;
            recent_next[1] = src_r2;
            recent_next[2] = rx_char;
            if (pos_eff >= 8'd3 && pos_eff <= 8'd5) begin
                type_next[2'(pos_eff - 8'd3)] = rx_char;
            end
            if (rx_char == CH_COMMA) begin
                field_next  = (src_field == FLD_MAX) ? src_field : src_field + 4'd1;
                offset_next = 4'd0;
            end else if (rx_char == CH_STAR) begin
                field_next  = FLD_MAX;
                offset_next = 4'd0;
            end else begin
                field_next      = src_field;
                offset_next     = (src_offset == FLD_MAX) ? src_offset : src_offset + 4'd1;
                cap_ctrl.wr     = !restart;
                cap_ctrl.field  = src_field;
                cap_ctrl.offset = src_offset;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 8'd0;
            xor_reg    <= 8'd0;
            recent_reg <= '{default: 8'd0};
            type_reg   <= '{default: 8'd0};
            field_reg  <= 4'd0;
            offset_reg <= 4'd0;
        end else if (step) begin
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            recent_reg <= recent_next;
            type_reg   <= type_next;
            field_reg  <= field_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nsp_capture.sv
// Field capture: shadow bytes; fix_char from each valid RMC, other fields only if it is A.
`default_nettype none

module nsp_capture
    import nsp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cap_ctrl_t cap_ctrl,
    output fix_fields_t fields
);

    logic [7:0] time_sh_reg [TIME_LEN];
    logic [7:0] lat_sh_reg  [LAT_LEN];
    logic [7:0] lon_sh_reg  [LON_LEN];
    logic [7:0] date_sh_reg [DATE_LEN];
    logic [7:0] stat_sh_reg;
    logic [7:0] ns_sh_reg;
    logic [7:0] ew_sh_reg;

    logic [7:0] time_reg [TIME_LEN];
    logic [7:0] lat_reg  [LAT_LEN];
    logic [7:0] lon_reg  [LON_LEN];
    logic [7:0] date_reg [DATE_LEN];
    logic [7:0] stat_reg;
    logic [7:0] ns_reg;
    logic [7:0] ew_reg;

    logic commit_stat;
    logic commit_all;

    assign commit_stat = cap_ctrl.step && cap_ctrl.commit;
    assign commit_all  = commit_stat && (stat_sh_reg == CH_FIX_OK);

    // shadow captures: clear on any frame end or restart, else write the addressed byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (cap_ctrl.step && cap_ctrl.clear)) begin
            time_sh_reg <= '{default: 8'd0};
            lat_sh_reg  <= '{default: 8'd0};
            lon_sh_reg  <= '{default: 8'd0};
            date_sh_reg <= '{default: 8'd0};
            stat_sh_reg <= 8'd0;
            ns_sh_reg   <= 8'd0;
            ew_sh_reg   <= 8'd0;
        end else if (cap_ctrl.step && cap_ctrl.wr) begin
            for (int i = 0; i < TIME_LEN; i++) begin
                if (cap_ctrl.field == FLD_TIME && cap_ctrl.offset == 4'(i)) begin
                    time_sh_reg[i] <= cap_ctrl.data;
                end
            end
            for (int i = 0; i < LAT_LEN; i++) begin
                if (cap_ctrl.field == FLD_LAT && cap_ctrl.offset == 4'(i)) begin
                    lat_sh_reg[i] <= cap_ctrl.data;
                end
            end
            for (int i = 0; i < LON_LEN; i++) begin
                if (cap_ctrl.field == FLD_LON && cap_ctrl.offset == 4'(i)) begin
                    lon_sh_reg[i] <= cap_ctrl.data;
                end
            end
            for (int i = 0; i < DATE_LEN; i++) begin
                if (cap_ctrl.field == FLD_DATE && cap_ctrl.offset == 4'(i)) begin
                    date_sh_reg[i] <= cap_ctrl.data;
                end
            end
            if (cap_ctrl.field == FLD_STAT && cap_ctrl.offset == 4'd0) begin
                stat_sh_reg <= cap_ctrl.data;
            end
            if (cap_ctrl.field == FLD_NS && cap_ctrl.offset == 4'd0) begin
                ns_sh_reg <= cap_ctrl.data;
            end
            if (cap_ctrl.field == FLD_EW && cap_ctrl.offset == 4'd0) begin
                ew_sh_reg <= cap_ctrl.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '{default: 8'd0};
            lat_reg  <= '{default: 8'd0};
            lon_reg  <= '{default: 8'd0};
            date_reg <= '{default: 8'd0};
            stat_reg <= 8'd0;
            ns_reg   <= 8'd0;
            ew_reg   <= 8'd0;
        end else begin
            if (commit_stat) begin
                stat_reg <= stat_sh_reg;
            end
            if (commit_all) begin
                time_reg <= time_sh_reg;
                lat_reg  <= lat_sh_reg;
                lon_reg  <= lon_sh_reg;
                date_reg <= date_sh_reg;
                ns_reg   <= ns_sh_reg;
                ew_reg   <= ew_sh_reg;
            end
        end
    end

    assign fields.fix_char    = stat_reg;
    assign fields.north_south = ns_reg;
    assign fields.east_west   = ew_reg;
    assign fields.fix_date    = {date_reg[0], date_reg[1], date_reg[2],
                                 date_reg[3], date_reg[4], date_reg[5]};
    assign fields.time_head   = {time_reg[0], time_reg[1], time_reg[2], time_reg[3],
                                 time_reg[4], time_reg[5], time_reg[6], time_reg[7]};
    assign fields.time_tail   = time_reg[8];
    assign fields.lat_head    = {lat_reg[0], lat_reg[1], lat_reg[2], lat_reg[3],
                                 lat_reg[4], lat_reg[5], lat_reg[6], lat_reg[7]};
    assign fields.lat_tail    = {lat_reg[8], lat_reg[9]};
    assign fields.lon_head    = {lon_reg[0], lon_reg[1], lon_reg[2], lon_reg[3],
                                 lon_reg[4], lon_reg[5], lon_reg[6], lon_reg[7]};
    assign fields.lon_tail    = {lon_reg[8], lon_reg[9]};

endmodule

`default_nettype wire

FILE: hw/rtl/nmea_sentence_parser_top.sv
// Top level of the NMEA sentence parser: stream ports, input and result registers.
`default_nettype none

// Channel  Dir  Width       Contents
// s_       in   8           rx_char, one received character per transfer
// m_       out  312 + 2     code and stored fix fields on tdata, sentence_kind on tuser
//
// Each character yields exactly one result transfer, through the input register and then the result register.
// One character per cycle is sustained while m_tready stays high; the frame state updates as each character advances.
// Synchronous active-low reset clears the frame state and the stored fields to zero.
// A stalled result holds the input register; s_tready drops only when both are full.

module nmea_sentence_parser_top
    import nsp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_char
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [1:0] code, [9:2] fix_char, [17:10] north_south, [25:18] east_west,
    // [73:26] fix_date, [137:74] time_head, [145:138] time_tail,
    // [209:146] lat_head, [225:210] lat_tail, [289:226] lon_head,
    // [305:290] lon_tail, [311:306] zero
    output logic [311:0]      m_tdata,
    output logic [1:0]        m_tuser    // [1:0] sentence_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg;
    code_t       code_reg;
    kind_t       kind_reg;
    logic        advance;
    code_t       code_next;
    kind_t       kind_next;
    cap_ctrl_t   cap_ctrl;
    fix_fields_t fields;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            code_reg <= code_next;
            kind_reg <= kind_next;
        end
    end

    nsp_frame #(
        .MAX_LEN (MAX_LEN)
    ) u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_char  (in_char_reg),
        .cap_ctrl (cap_ctrl),
        .code     (code_next),
        .kind     (kind_next)
    );

    nsp_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cap_ctrl (cap_ctrl),
        .fields   (fields)
    );

    assign m_tdata = {6'd0,
                      fields.lon_tail, fields.lon_head,
                      fields.lat_tail, fields.lat_head,
                      fields.time_tail, fields.time_head,
                      fields.fix_date, fields.east_west,
                      fields.north_south, fields.fix_char,
                      code_reg};
    assign m_tuser = kind_reg;

    // a completed sentence kind is only reported with a clean code
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && kind_reg != KIND_NONE |-> code_reg == CODE_OK)
        else $error("sentence kind reported with error code");

    // stored fields change only on a result that reports an RMC sentence
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(fields) |-> out_valid_reg && kind_reg == KIND_RMC)
        else $error("stored fields changed without an RMC result");

    // input stalls only when both the input and result registers are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with free space");

    // a held input character is not lost while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))
        else $error("held input character lost");

endmodule

`default_nettype wire
